### sv/gregorian_date_arithmetic_assert.svh
// ----------------------------------------------------------------------------
// Gregorian date arithmetic assertion macros
// Concurrent assertion wrappers, clocked on clk_i; GDA_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked at every edge outside reset.
`define GDA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gregorian_date_arithmetic assertion failed");

// Checked at every edge, reset included.
`define GDA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("gregorian_date_arithmetic assertion failed");

`else

`define GDA_ASSERT(lbl, prop)
`define GDA_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date arithmetic package
// Widths, calendar constants, state and step tables of the date unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gda_pkg;

  localparam int MAX_YEAR    = 9999;
  localparam int SHIFT_YEARS = 6400;
  localparam int DAYS_400    = 146097;
  localparam int DAYS_100    = 36524;
  localparam int DAYS_4      = 1461;
  localparam int DAYS_1      = 365;

  localparam int NUM_W   = 24;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int OFF_W   = 20;
  localparam int DIFF_W  = 22;
  localparam int CMD_W   = 2;
  localparam int STEP_W  = 4;

  localparam int DIFF_MAX = (2 ** DIFF_W) - 1;

  localparam logic [STEP_W-1:0] Y2N_LAST = 4'd14;
  localparam logic [STEP_W-1:0] N2Y_LAST = 4'd15;
  localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = 4'd11;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_SUB  = 2'd1,
    CMD_DIFF = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y2N,
    ST_FIX,
    ST_OFFS,
    ST_N2Y,
    ST_MONTH,
    ST_DIFF,
    ST_NULL
  } state_e;

  typedef enum logic [1:0] {
    GRP_400,
    GRP_100,
    GRP_4,
    GRP_1
  } grp_e;

  typedef struct packed {
    logic [NUM_W-1:0] sub_amt;
    logic [NUM_W-1:0] add_amt;
    grp_e             grp;
    logic [2:0]       bit_idx;
  } step_t;

  // One restoring step of the year/day conversion. Toward day numbers the
  // year count is taken apart in 400, 100, 4 and 1 year units while the
  // matching day counts are summed; toward years the roles swap.
  function automatic step_t step_info(logic n2y, logic [STEP_W-1:0] idx);
    step_t      s;
    logic [2:0] sh;
    logic [NUM_W-1:0] yrs;
    logic [NUM_W-1:0] dys;
    s   = '{sub_amt: '0, add_amt: '0, grp: GRP_400, bit_idx: '0};
    sh  = '0;
    yrs = '0;
    dys = '0;
    if (!n2y) begin
      if (idx < 4'd6) begin
        sh = 3'(4'd5 - idx);  yrs = NUM_W'(400); dys = NUM_W'(DAYS_400); s.grp = GRP_400;
      end else if (idx < 4'd8) begin
        sh = 3'(4'd7 - idx);  yrs = NUM_W'(100); dys = NUM_W'(DAYS_100); s.grp = GRP_100;
      end else if (idx < 4'd13) begin
        sh = 3'(4'd12 - idx); yrs = NUM_W'(4);   dys = NUM_W'(DAYS_4);   s.grp = GRP_4;
      end else begin
        sh = 3'(4'd14 - idx); yrs = NUM_W'(1);   dys = NUM_W'(DAYS_1);   s.grp = GRP_1;
      end
      s.sub_amt = yrs << sh;
      s.add_amt = dys << sh;
    end else begin
      if (idx < 4'd7) begin
        sh = 3'(4'd6 - idx);  yrs = NUM_W'(400); dys = NUM_W'(DAYS_400); s.grp = GRP_400;
      end else if (idx < 4'd9) begin
        sh = 3'(4'd8 - idx);  yrs = NUM_W'(100); dys = NUM_W'(DAYS_100); s.grp = GRP_100;
      end else if (idx < 4'd14) begin
        sh = 3'(4'd13 - idx); yrs = NUM_W'(4);   dys = NUM_W'(DAYS_4);   s.grp = GRP_4;
      end else begin
        sh = 3'(4'd15 - idx); yrs = NUM_W'(1);   dys = NUM_W'(DAYS_1);   s.grp = GRP_1;
      end
      s.sub_amt = dys << sh;
      s.add_amt = yrs << sh;
    end
    s.bit_idx = sh;
    return s;
  endfunction

  function automatic logic [8:0] month_start(logic [MONTH_W-1:0] mi);
    logic [8:0] v;
    unique case (mi)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] mi);
    logic [DAY_W-1:0] v;
    unique case (mi) inside
      4'd1:                         v = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:      v = 5'd30;
      default:                      v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// Gregorian date arithmetic unit
// Adds days to a date, subtracts days from it, or counts the days between
// two dates in the proleptic Gregorian calendar.
//
// The input channel (in_valid_i, in_stall_o) carries a command, a first date,
// a day offset and a second date. The output channel (out_valid_o,
// out_stall_i) returns exactly one result per input transfer.
// Dates become day numbers and back through one shared compare, subtract and
// accumulate unit that works through 400, 100, 4 and 1 year units one
// restoring step per cycle, and then through the months one per cycle.
// Add and subtract run through Y2N, FIX, OFFS, N2Y and MONTH, difference
// through Y2N and FIX per date and then DIFF, and command 3 through NULL.
// One item is worked on at a time; in_stall_o is high until the result sits
// in the output register. A new item is taken while that result still waits.
// When the receiver stalls, the result is held in the output register and a
// finished next result waits in the unit until the register frees.
// Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gregorian_date_arithmetic_assert.svh"

module gregorian_date_arithmetic (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [gda_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [gda_pkg::DAY_W-1:0]    day_i,
  input  wire logic [gda_pkg::MONTH_W-1:0]  month_i,
  input  wire logic [gda_pkg::YEAR_W-1:0]   year_i,
  input  wire logic [gda_pkg::OFF_W-1:0]    offset_days_i,
  input  wire logic [gda_pkg::DAY_W-1:0]    other_day_i,
  input  wire logic [gda_pkg::MONTH_W-1:0]  other_month_i,
  input  wire logic [gda_pkg::YEAR_W-1:0]   other_year_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [gda_pkg::DAY_W-1:0]    res_day_o,
  output      logic [gda_pkg::MONTH_W-1:0]  res_month_o,
  output      logic [gda_pkg::YEAR_W-1:0]   res_year_o,
  output      logic [gda_pkg::DIFF_W-1:0]   day_difference_o,
  output      logic                         out_of_range_o
);

  localparam int NW = gda_pkg::NUM_W;

  gda_pkg::state_e state_q, state_d;

  logic [gda_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [gda_pkg::DAY_W-1:0]   day_q, day_d, oday_q, oday_d;
  logic [gda_pkg::MONTH_W-1:0] month_q, month_d, omonth_q, omonth_d;
  logic [gda_pkg::YEAR_W-1:0]  year_q, year_d, oyear_q, oyear_d;
  logic [gda_pkg::OFF_W-1:0]   off_q, off_d;
  logic                        sel_b_q, sel_b_d;

  logic [NW-1:0]                rem_q, rem_d, acc_q, acc_d, na_q, na_d;
  logic [gda_pkg::STEP_W-1:0]   step_q, step_d;
  logic [gda_pkg::MONTH_W-1:0]  mo_q, mo_d;
  logic [1:0]                   q100_q, q100_d, q1_q, q1_d;
  logic [4:0]                   q4_q, q4_d;

  logic                         out_valid_q, out_valid_d;
  logic [gda_pkg::DAY_W-1:0]    out_day_q, out_day_d;
  logic [gda_pkg::MONTH_W-1:0]  out_month_q, out_month_d;
  logic [gda_pkg::YEAR_W-1:0]   out_year_q, out_year_d;
  logic [gda_pkg::DIFF_W-1:0]   out_diff_q, out_diff_d;
  logic                         out_oor_q, out_oor_d;

  logic                         accept, out_free, load_out, leap, conv_last;
  gda_pkg::step_t               st;
  logic [NW-1:0]                add_op, sub_op, add_sum;
  logic [NW:0]                  sub_dif;
  logic                         borrow;
  logic [gda_pkg::DAY_W-1:0]    cur_day;
  logic [gda_pkg::MONTH_W-1:0]  cur_month, mi;
  logic [gda_pkg::YEAR_W-1:0]   cur_oyear;
  logic [9:0]                   addend;
  logic [gda_pkg::DAY_W-1:0]    mlen;
  logic [NW-1:0]                ys;
  logic [NW:0]                  ab_dif, ab_mag;
  logic                         year_ok, oyear_ok;

  assign accept   = in_valid_i && (state_q == gda_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign leap     = (q1_q == 2'd3) && ((q4_q != 5'd24) || (q100_q == 2'd3));

  assign st        = gda_pkg::step_info(state_q == gda_pkg::ST_N2Y, step_q);
  assign conv_last = (state_q == gda_pkg::ST_N2Y) ? (step_q == gda_pkg::N2Y_LAST)
                                                   : (step_q == gda_pkg::Y2N_LAST);

  assign cur_day   = sel_b_q ? oday_q : day_q;
  assign cur_month = sel_b_q ? omonth_q : month_q;
  assign cur_oyear = oyear_q;
  assign mi        = (cur_month == '0) ? '0 :
                     (cur_month > 4'd12) ? gda_pkg::LAST_MONTH_IDX : 4'(cur_month - 4'd1);
  assign addend    = 10'(gda_pkg::month_start(mi)) + 10'((mi >= 4'd2) && leap) +
                     10'(cur_day);
  assign mlen      = 5'(gda_pkg::month_len(mo_q) + 5'((mo_q == 4'd1) && leap));

  always_comb begin
    add_op = st.add_amt;
    sub_op = st.sub_amt;
    unique case (state_q)
      gda_pkg::ST_FIX:   add_op = NW'(addend) - NW'(1);
      gda_pkg::ST_OFFS:  add_op = (cmd_q == gda_pkg::CMD_ADD) ? NW'(off_q) : (NW'(0) - NW'(off_q));
      gda_pkg::ST_MONTH: sub_op = NW'(mlen);
      default: ;
    endcase
  end

  // Shared unit: accumulate and restoring compare-subtract.
  assign add_sum = acc_q + add_op;
  assign sub_dif = {1'b0, rem_q} - {1'b0, sub_op};
  assign borrow  = sub_dif[NW];

  assign ys     = acc_q + NW'(1);
  assign ab_dif = {1'b0, na_q} - {1'b0, acc_q};
  assign ab_mag = ab_dif[NW] ? ((NW+1)'(0) - ab_dif) : ab_dif;

  assign year_ok  = (year_q != '0) && (int'(year_q) <= gda_pkg::MAX_YEAR);
  assign oyear_ok = (cur_oyear != '0) && (int'(cur_oyear) <= gda_pkg::MAX_YEAR);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    off_d       = off_q;
    oday_d      = oday_q;
    omonth_d    = omonth_q;
    oyear_d     = oyear_q;
    sel_b_d     = sel_b_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    na_d        = na_q;
    step_d      = step_q;
    mo_d        = mo_q;
    q100_d      = q100_q;
    q4_d        = q4_q;
    q1_d        = q1_q;
    load_out    = 1'b0;
    out_day_d   = out_day_q;
    out_month_d = out_month_q;
    out_year_d  = out_year_q;
    out_diff_d  = out_diff_q;
    out_oor_d   = out_oor_q;

    unique case (state_q) inside
      gda_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          day_d    = day_i;
          month_d  = month_i;
          year_d   = year_i;
          off_d    = offset_days_i;
          oday_d   = other_day_i;
          omonth_d = other_month_i;
          oyear_d  = other_year_i;
          sel_b_d  = 1'b0;
          rem_d    = NW'(year_i) + NW'(gda_pkg::SHIFT_YEARS - 1);
          acc_d    = '0;
          step_d   = '0;
          q100_d   = '0;
          q4_d     = '0;
          q1_d     = '0;
          if (cmd_i == gda_pkg::CMD_ADD || cmd_i == gda_pkg::CMD_SUB ||
              cmd_i == gda_pkg::CMD_DIFF) begin
            state_d = gda_pkg::ST_Y2N;
          end else begin
            state_d = gda_pkg::ST_NULL;
          end
        end
      end

      gda_pkg::ST_Y2N, gda_pkg::ST_N2Y: begin
        if (!borrow) begin
          rem_d = sub_dif[NW-1:0];
          acc_d = add_sum;
          case (st.grp)
            gda_pkg::GRP_100: q100_d[st.bit_idx[0]] = 1'b1;
            gda_pkg::GRP_4:   q4_d[st.bit_idx]      = 1'b1;
            gda_pkg::GRP_1:   q1_d[st.bit_idx[0]]   = 1'b1;
            default: ;
          endcase
        end
        step_d = 4'(step_q + 4'd1);
        if (conv_last) begin
          if (state_q == gda_pkg::ST_N2Y) begin
            mo_d    = '0;
            state_d = gda_pkg::ST_MONTH;
          end else begin
            state_d = gda_pkg::ST_FIX;
          end
        end
      end

      gda_pkg::ST_FIX: begin
        acc_d = add_sum;
        if (cmd_q == gda_pkg::CMD_DIFF) begin
          if (!sel_b_q) begin
            na_d    = add_sum;
            sel_b_d = 1'b1;
            rem_d   = NW'(cur_oyear) + NW'(gda_pkg::SHIFT_YEARS - 1);
            acc_d   = '0;
            step_d  = '0;
            q100_d  = '0;
            q4_d    = '0;
            q1_d    = '0;
            state_d = gda_pkg::ST_Y2N;
          end else begin
            state_d = gda_pkg::ST_DIFF;
          end
        end else begin
          state_d = gda_pkg::ST_OFFS;
        end
      end

      gda_pkg::ST_OFFS: begin
        rem_d   = add_sum;
        acc_d   = '0;
        step_d  = '0;
        q100_d  = '0;
        q4_d    = '0;
        q1_d    = '0;
        state_d = gda_pkg::ST_N2Y;
      end

      gda_pkg::ST_MONTH: begin
        if (borrow || mo_q == gda_pkg::LAST_MONTH_IDX) begin
          if (out_free) begin
            load_out   = 1'b1;
            out_diff_d = '0;
            if (ys < NW'(gda_pkg::SHIFT_YEARS + 1)) begin
              out_oor_d   = 1'b1;
              out_day_d   = 5'd1;
              out_month_d = 4'd1;
              out_year_d  = 14'd1;
            end else if (ys > NW'(gda_pkg::SHIFT_YEARS + gda_pkg::MAX_YEAR)) begin
              out_oor_d   = 1'b1;
              out_day_d   = 5'd31;
              out_month_d = 4'd12;
              out_year_d  = gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR);
            end else begin
              out_oor_d   = 1'b0;
              out_day_d   = 5'(rem_q + NW'(1));
              out_month_d = 4'(mo_q + 4'd1);
              out_year_d  = gda_pkg::YEAR_W'(ys - NW'(gda_pkg::SHIFT_YEARS));
            end
            state_d = gda_pkg::ST_IDLE;
          end
        end else begin
          rem_d = sub_dif[NW-1:0];
          mo_d  = 4'(mo_q + 4'd1);
        end
      end

      gda_pkg::ST_DIFF: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_day_d   = '0;
          out_month_d = '0;
          out_year_d  = '0;
          out_diff_d  = (ab_mag > (NW+1)'(gda_pkg::DIFF_MAX)) ?
                        gda_pkg::DIFF_W'(gda_pkg::DIFF_MAX) : ab_mag[gda_pkg::DIFF_W-1:0];
          out_oor_d   = !(year_ok && oyear_ok);
          state_d     = gda_pkg::ST_IDLE;
        end
      end

      gda_pkg::ST_NULL: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_day_d   = '0;
          out_month_d = '0;
          out_year_d  = '0;
          out_diff_d  = '0;
          out_oor_d   = 1'b0;
          state_d     = gda_pkg::ST_IDLE;
        end
      end

      default: state_d = gda_pkg::ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gda_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    day_q       <= day_d;
    month_q     <= month_d;
    year_q      <= year_d;
    off_q       <= off_d;
    oday_q      <= oday_d;
    omonth_q    <= omonth_d;
    oyear_q     <= oyear_d;
    sel_b_q     <= sel_b_d;
    rem_q       <= rem_d;
    acc_q       <= acc_d;
    na_q        <= na_d;
    step_q      <= step_d;
    mo_q        <= mo_d;
    q100_q      <= q100_d;
    q4_q        <= q4_d;
    q1_q        <= q1_d;
    out_day_q   <= out_day_d;
    out_month_q <= out_month_d;
    out_year_q  <= out_year_d;
    out_diff_q  <= out_diff_d;
    out_oor_q   <= out_oor_d;
  end

  assign in_stall_o       = (state_q != gda_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign res_day_o        = out_day_q;
  assign res_month_o      = out_month_q;
  assign res_year_o       = out_year_q;
  assign day_difference_o = out_diff_q;
  assign out_of_range_o   = out_oor_q;

  `GDA_ASSERT(a_busy_after_transfer, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `GDA_ASSERT(a_y2n_step_bound, (state_q == gda_pkg::ST_Y2N) |-> (step_q <= gda_pkg::Y2N_LAST))
  `GDA_ASSERT(a_month_bound, (state_q == gda_pkg::ST_MONTH) |-> (mo_q <= gda_pkg::LAST_MONTH_IDX))
  `GDA_ASSERT(a_result_from_work, load_out |-> (state_q != gda_pkg::ST_IDLE))
  `GDA_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire
